### rtl/core/json_token_stream_writer_top_defines.svh
// Assertion macros for the token writer.
`ifndef JSON_TOKEN_STREAM_WRITER_TOP_DEFINES_SVH
`define JSON_TOKEN_STREAM_WRITER_TOP_DEFINES_SVH

`define JTW_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define JTW_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### rtl/core/jtw_pkg.sv
package jtw_pkg;
    localparam int MAX_DEPTH = 16;
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int LVL_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [3:0] TOK_ARR    = 4'd0;
    localparam logic [3:0] TOK_OBJ    = 4'd1;
    localparam logic [3:0] TOK_END    = 4'd2;
    localparam logic [3:0] TOK_NULL   = 4'd3;
    localparam logic [3:0] TOK_TRUE   = 4'd4;
    localparam logic [3:0] TOK_FALSE  = 4'd5;
    localparam logic [3:0] TOK_STRBEG = 4'd6;
    localparam logic [3:0] TOK_CHAR   = 4'd7;
    localparam logic [3:0] TOK_STREND = 4'd8;
    localparam logic [3:0] TOK_UINT   = 4'd9;
    localparam logic [3:0] TOK_SINT   = 4'd10;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_ODD      = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_STRING   = 3'd4;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  char_byte;
        logic [63:0] number_value;
    } tok_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] error;
    } res_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction
endpackage

### rtl/core/jtw_stream_if.sv
interface jtw_tok_if;
    logic             valid;
    logic             ready;
    jtw_pkg::tok_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jtw_res_if;
    logic             valid;
    logic             ready;
    jtw_pkg::res_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/json_token_stream_writer_top.sv
// Token writer: turns JSON tokens into JSON text bytes.
// Channel tok (sink) takes one token beat: func, char_byte, number_value.
// Channel res (source) gives one beat per output byte, with last on the
// final byte of a token and error on a single rejected-token beat.
// One token is taken at a time; ready is low until its last beat leaves.
// A token is decoded, then each output byte is one beat on res; a string
// character gives 1, 2 or 6 bytes. Integers run a shared divide by ten
// built on a 32x32 multiplier, one digit per division, up to 20 digits.
// Digits go into a 20-entry buffer and are sent most significant first.
// Unused token codes are taken and cause no beat.
// Reset empties the nesting stack and leaves string mode.
// When the receiver holds ready low, the current beat stays on res and
// the sequencer waits; nothing is dropped.
module json_token_stream_writer_top (
    input  logic clk,
    input  logic rst_n,
    jtw_tok_if.sink   tok,
    jtw_res_if.source res
);
    import jtw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EMIT = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DIG  = 3'd3;

    logic [2:0]  st_reg, st_next;
    logic [DEPTH_W-1:0] dep_reg, dep_next;
    logic        instr_reg, instr_next;
    logic [MAX_DEPTH-1:0] obj_mem, has_mem, odd_mem;
    logic [MAX_DEPTH-1:0] obj_next, has_next, odd_next;

    // small byte script: up to 8 bytes
    logic [7:0]  scr_reg [8];
    logic [7:0]  scr_next [8];
    logic [3:0]  slen_reg, slen_next;
    logic [3:0]  sidx_reg, sidx_next;
    logic        tonum_reg, tonum_next;
    logic [63:0] mag_reg, mag_next;
    logic [3:0]  dig_reg [20];
    logic [4:0]  dcnt_reg, dcnt_next;
    logic        dwr;
    logic        err_reg, err_next;
    logic [2:0]  ecode_reg, ecode_next;

    logic        dstart, ddone;
    logic [63:0] dq;
    logic [3:0]  dr;

    jtw_div10 u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(mag_next),
        .done(ddone), .quotient(dq), .remainder(dr)
    );

    logic [LVL_W-1:0] top_i, new_i;
    logic             sep_need;
    logic [7:0]       sep_byte;
    logic [3:0]       f;
    logic [7:0]       c;

    assign top_i = LVL_W'(dep_reg - DEPTH_W'(1));
    assign new_i = LVL_W'(dep_reg);
    assign f = tok.data.func;
    assign c = tok.data.char_byte;

    always_comb
    begin
        sep_need = (dep_reg != '0) && has_mem[top_i];
        sep_byte = (obj_mem[top_i] && odd_mem[top_i]) ? 8'h3A : 8'h2C;
    end

    assign tok.ready = (st_reg == ST_IDLE);

    always_comb
    begin
        logic [3:0] k;
        st_next = st_reg;
        dep_next = dep_reg;
        instr_next = instr_reg;
        obj_next = obj_mem;
        has_next = has_mem;
        odd_next = odd_mem;
        slen_next = slen_reg;
        sidx_next = sidx_reg;
        tonum_next = tonum_reg;
        mag_next = mag_reg;
        dcnt_next = dcnt_reg;
        err_next = err_reg;
        ecode_next = ecode_reg;
        dstart = 1'b0;
        dwr = 1'b0;
        k = 4'd0;
        for (int i = 0; i < 8; i++)
            scr_next[i] = scr_reg[i];
        case (st_reg)
            ST_IDLE:
            begin
                if (tok.valid && f <= TOK_SINT)
                begin
                    err_next = 1'b0;
                    tonum_next = 1'b0;
                    sidx_next = 4'd0;
                    st_next = ST_EMIT;
                    if (instr_reg != (f == TOK_CHAR || f == TOK_STREND))
                    begin
                        err_next = 1'b1;
                        ecode_next = ERR_STRING;
                    end
                    else if (f == TOK_END)
                    begin
                        if (dep_reg == '0)
                        begin
                            err_next = 1'b1;
                            ecode_next = ERR_EMPTY;
                        end
                        else if (obj_mem[top_i] && odd_mem[top_i])
                        begin
                            err_next = 1'b1;
                            ecode_next = ERR_ODD;
                        end
                        else
                        begin
                            scr_next[0] = obj_mem[top_i] ? 8'h7D : 8'h5D;
                            k = 4'd1;
                            dep_next = dep_reg - DEPTH_W'(1);
                        end
                    end
                    else if ((f == TOK_ARR || f == TOK_OBJ) &&
                             dep_reg >= DEPTH_W'(MAX_DEPTH))
                    begin
                        err_next = 1'b1;
                        ecode_next = ERR_OVERFLOW;
                    end
                    else if ((f == TOK_STRBEG || f == TOK_UINT || f == TOK_SINT) &&
                             dep_reg == '0)
                    begin
                        err_next = 1'b1;
                        ecode_next = ERR_EMPTY;
                    end
                    else if (f == TOK_CHAR)
                    begin
                        k = 4'd2;
                        scr_next[0] = 8'h5C;
                        case (c)
                            8'h22: scr_next[1] = 8'h22;
                            8'h5C: scr_next[1] = 8'h5C;
                            8'h0A: scr_next[1] = 8'h6E;
                            8'h0D: scr_next[1] = 8'h72;
                            8'h08: scr_next[1] = 8'h62;
                            8'h0C: scr_next[1] = 8'h66;
                            8'h09: scr_next[1] = 8'h74;
                            default:
                            begin
                                if (c < 8'h20 || c > 8'h7F)
                                begin
                                    scr_next[1] = 8'h75;
                                    scr_next[2] = 8'h30;
                                    scr_next[3] = 8'h30;
                                    scr_next[4] = hex_char(c[7:4]);
                                    scr_next[5] = hex_char(c[3:0]);
                                    k = 4'd6;
                                end
                                else
                                begin
                                    scr_next[0] = c;
                                    k = 4'd1;
                                end
                            end
                        endcase
                    end
                    else if (f == TOK_STREND)
                    begin
                        scr_next[0] = 8'h22;
                        k = 4'd1;
                        instr_next = 1'b0;
                    end
                    else
                    begin
                        if (sep_need)
                        begin
                            scr_next[0] = sep_byte;
                            k = 4'd1;
                        end
                        case (f)
                            TOK_ARR, TOK_OBJ:
                            begin
                                scr_next[k[2:0]] = (f == TOK_OBJ) ? 8'h7B : 8'h5B;
                                k = k + 4'd1;
                            end
                            TOK_NULL:
                            begin
                                scr_next[k[2:0]] = 8'h6E;
                                scr_next[3'(k + 4'd1)] = 8'h75;
                                scr_next[3'(k + 4'd2)] = 8'h6C;
                                scr_next[3'(k + 4'd3)] = 8'h6C;
                                k = k + 4'd4;
                            end
                            TOK_TRUE:
                            begin
                                scr_next[k[2:0]] = 8'h74;
                                scr_next[3'(k + 4'd1)] = 8'h72;
                                scr_next[3'(k + 4'd2)] = 8'h75;
                                scr_next[3'(k + 4'd3)] = 8'h65;
                                k = k + 4'd4;
                            end
                            TOK_FALSE:
                            begin
                                scr_next[k[2:0]] = 8'h66;
                                scr_next[3'(k + 4'd1)] = 8'h61;
                                scr_next[3'(k + 4'd2)] = 8'h6C;
                                scr_next[3'(k + 4'd3)] = 8'h73;
                                scr_next[3'(k + 4'd4)] = 8'h65;
                                k = k + 4'd5;
                            end
                            TOK_STRBEG:
                            begin
                                scr_next[k[2:0]] = 8'h22;
                                k = k + 4'd1;
                                instr_next = 1'b1;
                            end
                            default:
                            begin
                                tonum_next = 1'b1;
                                mag_next = tok.data.number_value;
                                if (f == TOK_SINT && tok.data.number_value[63])
                                begin
                                    scr_next[k[2:0]] = 8'h2D;
                                    k = k + 4'd1;
                                    mag_next = 64'd0 - tok.data.number_value;
                                end
                            end
                        endcase
                        if (dep_reg != '0)
                        begin
                            has_next[top_i] = 1'b1;
                            odd_next[top_i] = ~odd_mem[top_i];
                        end
                        if (f == TOK_ARR || f == TOK_OBJ)
                        begin
                            obj_next[new_i] = (f == TOK_OBJ);
                            has_next[new_i] = 1'b0;
                            odd_next[new_i] = 1'b0;
                            dep_next = dep_reg + DEPTH_W'(1);
                        end
                    end
                    slen_next = k;
                    if (tonum_next)
                    begin
                        dcnt_next = 5'd0;
                        if (k == 4'd0)
                        begin
                            st_next = ST_DIV;
                            dstart = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (res.ready)
                begin
                    if (err_reg || sidx_reg + 4'd1 >= slen_reg)
                    begin
                        if (tonum_reg && !err_reg)
                        begin
                            st_next = ST_DIV;
                            dstart = 1'b1;
                        end
                        else
                            st_next = ST_IDLE;
                    end
                    else
                        sidx_next = sidx_reg + 4'd1;
                end
            end
            ST_DIV:
            begin
                if (ddone)
                begin
                    dwr = 1'b1;
                    dcnt_next = dcnt_reg + 5'd1;
                    mag_next = dq;
                    if (dq == 64'd0 || dcnt_reg == 5'd19)
                        st_next = ST_DIG;
                    else
                        dstart = 1'b1;
                end
            end
            ST_DIG:
            begin
                if (res.ready)
                begin
                    dcnt_next = dcnt_reg - 5'd1;
                    if (dcnt_reg == 5'd1)
                        st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            dep_reg <= '0;
            instr_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            dep_reg <= dep_next;
            instr_reg <= instr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obj_mem <= obj_next;
        has_mem <= has_next;
        odd_mem <= odd_next;
        slen_reg <= slen_next;
        sidx_reg <= sidx_next;
        tonum_reg <= tonum_next;
        mag_reg <= mag_next;
        dcnt_reg <= dcnt_next;
        err_reg <= err_next;
        ecode_reg <= ecode_next;
        for (int i = 0; i < 8; i++)
            scr_reg[i] <= scr_next[i];
        if (dwr)
            dig_reg[dcnt_reg] <= dr;
    end

    always_comb
    begin
        res.valid = (st_reg == ST_EMIT) || (st_reg == ST_DIG);
        res.data.out_byte = scr_reg[sidx_reg[2:0]];
        res.data.error = ERR_OK;
        res.data.last = (sidx_reg + 4'd1 >= slen_reg) && !tonum_reg;
        if (st_reg == ST_EMIT && err_reg)
        begin
            res.data.out_byte = 8'h00;
            res.data.error = ecode_reg;
            res.data.last = 1'b1;
        end
        else if (st_reg == ST_DIG)
        begin
            res.data.out_byte = 8'h30 + {4'd0, dig_reg[dcnt_reg - 5'd1]};
            res.data.last = (dcnt_reg == 5'd1);
        end
    end
endmodule

### rtl/core/jtw_div10.sv
module jtw_div10 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient,
    output logic [3:0]  remainder
);
    import jtw_pkg::*;

    localparam logic [63:0] RECIP = 64'hCCCC_CCCC_CCCC_CCCD;

    logic [63:0]  x_reg, x_next;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] addend;
    logic [63:0]  q;
    logic [63:0]  q10;
    logic [63:0]  rem_full;

    always_comb
    begin
        mul_a = x_reg[31:0];
        mul_b = RECIP[31:0];
        case (step_reg)
            3'd1:
            begin
                mul_a = x_reg[63:32];
            end
            3'd2:
            begin
                mul_b = RECIP[63:32];
            end
            3'd3:
            begin
                mul_a = x_reg[63:32];
                mul_b = RECIP[63:32];
            end
            default:
            begin
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        case (step_reg)
            3'd0: addend = {64'd0, prod};
            3'd3: addend = {prod, 64'd0};
            default: addend = {32'd0, prod, 32'd0};
        endcase

        x_next = x_reg;
        acc_next = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next = dividend;
            acc_next = '0;
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd4)
                busy_next = 1'b0;
            else
            begin
                acc_next = acc_reg + addend;
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        acc_reg <= acc_next;
    end

    assign q = {3'd0, acc_reg[127:67]};
    assign q10 = {q[60:0], 3'd0} + {q[62:0], 1'b0};
    assign rem_full = x_reg - q10;

    assign done = busy_reg && (step_reg == 3'd4);
    assign quotient = q;
    assign remainder = rem_full[3:0];
endmodule

### rtl/core/jtw_checker.sv
`include "json_token_stream_writer_top_defines.svh"
module jtw_checker (
    input logic clk,
    input logic rst_n,
    input logic tok_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_last,
    input logic [2:0] res_error,
    input logic [7:0] res_byte
);
    import jtw_pkg::*;
    `JTW_ASSERT_IMPL(a_err_last, clk, rst_n, res_valid && res_error != ERR_OK, res_last)
    `JTW_ASSERT_IMPL(a_err_zero, clk, rst_n, res_valid && res_error != ERR_OK, res_byte == 8'h00)
    `JTW_ASSERT_IMPL(a_no_overlap, clk, rst_n, tok_ready, !res_valid)
    `JTW_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_byte))
endmodule

bind json_token_stream_writer_top jtw_checker u_jtw_checker (
    .clk(clk), .rst_n(rst_n), .tok_ready(tok.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_last(res.data.last),
    .res_error(res.data.error), .res_byte(res.data.out_byte)
);

### dv/tb_json_token_stream_writer_top.sv
`timescale 1ns / 1ps

module tb_json_token_stream_writer_top;
    import jtw_pkg::*;

    localparam int LIMIT = 3000000;

    class json_text_scoreboard;
        bit     lvl_obj[MAX_DEPTH];
        bit     lvl_has[MAX_DEPTH];
        bit     lvl_odd[MAX_DEPTH];
        int     depth;
        bit     in_str;
        res_t   text_q[$];

        function new();
            depth = 0;
            in_str = 0;
        endfunction

        function void put(logic [7:0] b);
            res_t r;
            r.out_byte = b;
            r.last = 1'b0;
            r.error = ERR_OK;
            text_q.insert(text_q.size(), r);
        endfunction

        function void put_err(logic [2:0] code);
            res_t r;
            r.out_byte = 8'h00;
            r.last = 1'b1;
            r.error = code;
            text_q.insert(text_q.size(), r);
        endfunction

        function void put_str(string s);
            for (int i = 0; i < s.len(); i++)
                put(s[i]);
        endfunction

        function void separator();
            int t;
            if (depth == 0)
                return;
            t = depth - 1;
            if (lvl_has[t])
                put((!lvl_obj[t] || !lvl_odd[t]) ? "," : ":");
            lvl_has[t] = 1;
            lvl_odd[t] ^= 1'b1;
        endfunction

        function void put_decimal(logic [63:0] v);
            logic [7:0] d[$];
            do
            begin
                d.push_front(8'h30 + 8'(v % 64'd10));
                v = v / 64'd10;
            end
            while (v != 0);
            foreach (d[i])
                put(d[i]);
        endfunction

        function logic [7:0] hexdig(logic [3:0] v);
            return (v < 10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
        endfunction

        function void put_escaped(logic [7:0] c);
            case (c)
                8'h22: put_str("\\\"");
                8'h5C: put_str("\\\\");
                8'h0A: put_str("\\n");
                8'h0D: put_str("\\r");
                8'h08: put_str("\\b");
                8'h0C: put_str("\\f");
                8'h09: put_str("\\t");
                default:
                    if (c < 8'h20 || c > 8'h7F)
                    begin
                        put_str("\\u00");
                        put(hexdig(c[7:4]));
                        put(hexdig(c[3:0]));
                    end
                    else
                        put(c);
            endcase
        endfunction

        function void note_token(tok_t t);
            int n0;
            n0 = text_q.size();
            if (t.func > TOK_SINT)
                return;
            if (in_str != (t.func == TOK_CHAR || t.func == TOK_STREND))
            begin
                put_err(ERR_STRING);
                return;
            end
            case (t.func)
                TOK_ARR, TOK_OBJ:
                begin
                    if (depth >= MAX_DEPTH)
                    begin
                        put_err(ERR_OVERFLOW);
                        return;
                    end
                    separator();
                    lvl_obj[depth] = (t.func == TOK_OBJ);
                    lvl_has[depth] = 0;
                    lvl_odd[depth] = 0;
                    depth++;
                    put(t.func == TOK_OBJ ? "{" : "[");
                end
                TOK_END:
                begin
                    if (depth == 0)
                    begin
                        put_err(ERR_EMPTY);
                        return;
                    end
                    if (lvl_obj[depth-1] && lvl_odd[depth-1])
                    begin
                        put_err(ERR_ODD);
                        return;
                    end
                    put(lvl_obj[depth-1] ? "}" : "]");
                    depth--;
                end
                TOK_NULL:  begin separator(); put_str("null");  end
                TOK_TRUE:  begin separator(); put_str("true");  end
                TOK_FALSE: begin separator(); put_str("false"); end
                TOK_STRBEG:
                begin
                    if (depth == 0)
                    begin
                        put_err(ERR_EMPTY);
                        return;
                    end
                    separator();
                    put("\"");
                    in_str = 1;
                end
                TOK_CHAR: put_escaped(t.char_byte);
                TOK_STREND:
                begin
                    put("\"");
                    in_str = 0;
                end
                default:
                begin
                    if (depth == 0)
                    begin
                        put_err(ERR_EMPTY);
                        return;
                    end
                    separator();
                    if (t.func == TOK_SINT && t.number_value[63])
                    begin
                        put("-");
                        put_decimal(-t.number_value);
                    end
                    else
                        put_decimal(t.number_value);
                end
            endcase
            if (text_q.size() > n0)
                text_q[$].last = 1'b1;
        endfunction

        function string check_byte(res_t got);
            res_t want;
            if (text_q.size() == 0)
                return $sformatf("unexpected beat byte=%h last=%b err=%0d",
                                 got.out_byte, got.last, got.error);
            want = text_q.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last
                || got.error !== want.error)
                return $sformatf("got byte=%h last=%b err=%0d, want byte=%h last=%b err=%0d",
                                 got.out_byte, got.last, got.error,
                                 want.out_byte, want.last, want.error);
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    jtw_tok_if tok();
    jtw_res_if res();

    json_token_stream_writer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok.sink),
        .res   (res.source)
    );

    json_text_scoreboard sb;
    int  fail_count;
    int  cycles;
    int  gap_pct;
    int  stall_pct;
    bit  rx_hold;
    int  taken;
    int  pressure_start;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycles <= cycles + 1;

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && res.valid && res.ready)
        begin
            msg = sb.check_byte(res.data);
            if (msg != "")
                report(msg);
        end
        res.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    task automatic send(logic [3:0] f, logic [7:0] c, logic [63:0] v);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            tok.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok.valid <= 1'b1;
        tok.data.func <= f;
        tok.data.char_byte <= c;
        tok.data.number_value <= v;
        do
            @(posedge clk);
        while (!tok.ready);
        sb.note_token(tok.data);
        if (f <= TOK_SINT)
            taken++;
    endtask

    function automatic logic [63:0] rand_number();
        case ($urandom_range(3))
            0: return 64'($urandom_range(9));
            1: return 64'($urandom_range(99999));
            2: return -64'($urandom_range(99999));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] specials[9] = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h08, 8'h0C,
                                    8'h09, 8'h7F, 8'h1F};
        if ($urandom_range(3) == 0)
            return specials[$urandom_range(8)];
        return 8'($urandom());
    endfunction

    // pick a token that keeps the text well formed, with some noise
    task automatic send_random();
        int t;
        int p;
        logic [3:0] f;
        t = sb.depth - 1;
        p = $urandom_range(99);
        if (p < 7)
            f = 4'($urandom());
        else if (sb.in_str)
            f = (p < 80) ? TOK_CHAR : TOK_STREND;
        else if (sb.depth == 0)
            f = (p < 50) ? TOK_ARR : TOK_OBJ;
        else if (sb.lvl_obj[t] && !sb.lvl_odd[t])
            f = (p < 75) ? TOK_STRBEG : TOK_END;
        else if (p < 20)
            f = (sb.depth < MAX_DEPTH - 2) ? 4'($urandom_range(TOK_ARR, TOK_OBJ)) : TOK_END;
        else if (p < 30)
            f = TOK_END;
        else
        begin
            case ($urandom_range(5))
                0: f = TOK_NULL;
                1: f = TOK_TRUE;
                2: f = TOK_FALSE;
                3: f = TOK_STRBEG;
                4: f = TOK_UINT;
                default: f = TOK_SINT;
            endcase
        end
        send(f, rand_char(), rand_number());
    endtask

    initial
    begin
        rx_hold = 1'b0;
        wait (pressure_start == 1);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] chars[12] = '{8'h00, 8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h08,
                                  8'h0C, 8'h09, 8'h7F, 8'h80, 8'hFF, 8'h61};
        int waited;
        sb = new();
        fail_count = 0;
        taken = 0;
        gap_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        tok.valid = 1'b0;
        tok.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(TOK_END, 8'h00, 64'd0);
        send(TOK_STRBEG, 8'h00, 64'd0);
        send(TOK_UINT, 8'h00, 64'd5);
        send(TOK_SINT, 8'h00, 64'd5);
        send(TOK_CHAR, 8'hFF, 64'd0);
        send(4'hF, 8'hFF, '1);
        send(TOK_ARR, 8'h00, 64'd0);
        send(TOK_NULL, 8'h00, 64'd0);
        send(TOK_TRUE, 8'h00, 64'd0);
        send(TOK_FALSE, 8'h00, 64'd0);
        send(TOK_UINT, 8'h00, 64'd0);
        send(TOK_UINT, 8'h00, '1);
        send(TOK_SINT, 8'h00, 64'h8000_0000_0000_0000);
        send(TOK_SINT, 8'h00, '1);
        send(TOK_SINT, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF);
        send(TOK_STRBEG, 8'h00, 64'd0);
        send(TOK_NULL, 8'h00, 64'd0);
        foreach (chars[i])
            send(TOK_CHAR, chars[i], 64'd0);
        send(TOK_STREND, 8'h00, 64'd0);
        send(TOK_STREND, 8'h00, 64'd0);
        send(TOK_OBJ, 8'h00, 64'd0);
        send(TOK_STRBEG, 8'h00, 64'd0);
        send(TOK_STREND, 8'h00, 64'd0);
        send(TOK_END, 8'h00, 64'd0);
        send(TOK_UINT, 8'h00, 64'd1);
        send(TOK_END, 8'h00, 64'd0);
        send(TOK_END, 8'h00, 64'd0);
        repeat (MAX_DEPTH - 1) send(TOK_OBJ, 8'h00, 64'd0);
        send(TOK_ARR, 8'h00, 64'd0);
        send(TOK_OBJ, 8'h00, 64'd0);
        repeat (MAX_DEPTH + 1) send(TOK_END, 8'h00, 64'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 37) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 37) : 0;
            taken = 0;
            while (taken < 75)
            begin
                if (ph == 0 && taken == 20)
                    pressure_start = 1;
                send_random();
            end
        end

        tok.valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        waited = 0;
        while (sb.text_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && sb.text_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
